### design/psb_pkg.sv
// ----------------------------------------------------------------------------
// psb_pkg
// Shared types and constants for the palette sprite blitter.
// ----------------------------------------------------------------------------
package psb_pkg;

    localparam int DATA_W  = 32;
    localparam int SLOT_W  = 4;
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 4;
    localparam int NPIX_W  = 3;
    localparam int SIZE_W  = 11;
    localparam int TIDX_W  = 8;
    localparam int STRD_W  = 16;
    localparam int MODE_W  = 2;
    localparam int ADDR_W  = 5;
    localparam int REGI_W  = 3;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [MODE_W-1:0] MODE_1BPP   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_2BPP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_4BPP   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DIRECT = 2'd3;

    localparam logic [REGI_W-1:0] REG_PIXEL_MODE  = 3'd0;
    localparam logic [REGI_W-1:0] REG_TRANSPARENT = 3'd1;
    localparam logic [REGI_W-1:0] REG_WIDTH       = 3'd2;
    localparam logic [REGI_W-1:0] REG_HEIGHT      = 3'd3;
    localparam logic [REGI_W-1:0] REG_DEST_START  = 3'd4;
    localparam logic [REGI_W-1:0] REG_DEST_STRIDE = 3'd5;

    typedef enum logic [0:0] {
        KIND_PALETTE = 1'b0,
        KIND_SOURCE  = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [SLOT_W-1:0]  slot;
        logic [DATA_W-1:0]  data;
        logic [NPIX_W-1:0]  npix_m1;
    } entry_t;

    typedef struct packed {
        logic [MODE_W-1:0]  pixel_mode;
        logic [TIDX_W-1:0]  transparent_index;
        logic [SIZE_W-1:0]  sprite_width;
        logic [SIZE_W-1:0]  sprite_height;
        logic [DATA_W-1:0]  dest_start;
        logic [STRD_W-1:0]  dest_stride;
    } cfg_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } fifo_head_t;

endpackage

### design/psb_front.sv
// ----------------------------------------------------------------------------
// psb_front
// Input side: accepts words, classifies them and queues work for the back end.
// ----------------------------------------------------------------------------
module psb_front #(
    parameter int PALETTE_DEPTH = 16
) (
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         op,
    input  logic [psb_pkg::SLOT_W-1:0]   palette_slot,
    input  logic [psb_pkg::DATA_W-1:0]   data,
    input  logic [psb_pkg::MODE_W-1:0]   pixel_mode,
    input  logic                         fifo_full,
    output logic                         push,
    output psb_pkg::entry_t              push_entry
);
    import psb_pkg::*;

    logic slot_ok;

    assign in_stall = fifo_full;
    // writes to nonexistent palette slots are accepted and dropped
    assign slot_ok  = ({1'b0, palette_slot} < (SLOT_W+1)'(PALETTE_DEPTH));
    assign push     = in_valid && !fifo_full && (op || slot_ok);

    always_comb
    begin
        push_entry.kind = op ? KIND_SOURCE : KIND_PALETTE;
        push_entry.slot = palette_slot;
        push_entry.data = data;
        unique case (pixel_mode)
            MODE_1BPP:   push_entry.npix_m1 = 3'd7;
            MODE_2BPP:   push_entry.npix_m1 = 3'd3;
            MODE_4BPP:   push_entry.npix_m1 = 3'd1;
            MODE_DIRECT: push_entry.npix_m1 = 3'd0;
            default:     push_entry.npix_m1 = 3'd0;
        endcase
    end

endmodule

### design/psb_fifo.sv
// ----------------------------------------------------------------------------
// psb_fifo
// Short work queue between the front and the back end.
// ----------------------------------------------------------------------------
module psb_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  psb_pkg::entry_t      push_entry,
    output logic                 full,
    input  logic                 pop,
    output psb_pkg::fifo_head_t  head
);
    import psb_pkg::*;

    entry_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 do_pop;

    assign full       = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### design/psb_back.sv
// ----------------------------------------------------------------------------
// psb_back
// Pixel engine: palette writes, pixel unpack, lookup, addressing, output reg.
// ----------------------------------------------------------------------------
module psb_back #(
    parameter int MAX_DIM       = 1024,
    parameter int PALETTE_DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  psb_pkg::cfg_t                cfg,
    input  psb_pkg::fifo_head_t          head,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [psb_pkg::DATA_W-1:0]   address,
    output logic [psb_pkg::DATA_W-1:0]   color,
    output logic                         write_enable,
    output logic                         sprite_done,
    output logic                         last
);
    import psb_pkg::*;

    localparam int CNT_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = ($clog2(MAX_DIM) + 1 > SIZE_W) ? $clog2(MAX_DIM) + 1 : SIZE_W;
    localparam int PAL_AW = $clog2(PALETTE_DEPTH);

    logic [DATA_W-1:0]  palette_reg [PALETTE_DEPTH];

    logic               cur_valid_reg, cur_valid_next;
    entry_t             cur_reg;
    logic [BYTE_W-1:0]  sh_reg, sh_next;
    logic [NPIX_W-1:0]  pix_reg, pix_next;

    logic [CNT_W-1:0]   col_reg, col_next;
    logic [CNT_W-1:0]   row_reg, row_next;
    logic [DATA_W-1:0]  row_addr_reg, row_addr_next;

    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  address_reg, color_reg;
    logic               we_reg, done_reg, last_reg;

    logic [DIM_W-1:0]   w, h;
    logic               is_pal, out_free, step, emit, finish, load;
    logic               row_end, sprite_end;
    logic [DATA_W-1:0]  base, pix_addr;
    logic [IDX_W-1:0]   idx;
    logic               pix_we;
    logic [DATA_W-1:0]  pix_color;

    always_comb
    begin
        w = DIM_W'(cfg.sprite_width);
        if (cfg.sprite_width == '0)
        begin
            w = DIM_W'(1);
        end
        else if (DIM_W'(cfg.sprite_width) > DIM_W'(MAX_DIM))
        begin
            w = DIM_W'(MAX_DIM);
        end
        h = DIM_W'(cfg.sprite_height);
        if (cfg.sprite_height == '0)
        begin
            h = DIM_W'(1);
        end
        else if (DIM_W'(cfg.sprite_height) > DIM_W'(MAX_DIM))
        begin
            h = DIM_W'(MAX_DIM);
        end
    end

    assign is_pal   = (cur_reg.kind == KIND_PALETTE);
    assign out_free = !out_valid_reg || !out_stall;
    assign step     = cur_valid_reg && (is_pal || out_free);
    assign emit     = step && !is_pal;

    assign row_end    = (DIM_W'(col_reg) + 1'b1 >= w);
    assign sprite_end = row_end && (DIM_W'(row_reg) + 1'b1 >= h);
    assign finish     = step && (is_pal || row_end || pix_reg == cur_reg.npix_m1);
    assign load       = (!cur_valid_reg || finish) && head.valid;
    assign pop        = load;

    assign base     = (row_reg == '0 && col_reg == '0) ? cfg.dest_start : row_addr_reg;
    assign pix_addr = base + DATA_W'({col_reg, 2'b00});

    always_comb
    begin
        case (cfg.pixel_mode)
            MODE_1BPP: idx = {3'b000, sh_reg[7]};
            MODE_2BPP: idx = {2'b00, sh_reg[7:6]};
            default:   idx = sh_reg[7:4];
        endcase
        if (cfg.pixel_mode == MODE_DIRECT)
        begin
            pix_we    = 1'b1;
            pix_color = cur_reg.data;
        end
        else
        begin
            pix_we    = ({4'b0000, idx} != cfg.transparent_index);
            pix_color = '0;
            if (pix_we && ({1'b0, idx} < (IDX_W+1)'(PALETTE_DEPTH)))
            begin
                pix_color = palette_reg[idx[PAL_AW-1:0]];
            end
        end
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        sh_next        = sh_reg;
        pix_next       = pix_reg;
        if (load)
        begin
            cur_valid_next = 1'b1;
            sh_next        = head.entry.data[BYTE_W-1:0];
            pix_next       = '0;
        end
        else if (finish)
        begin
            cur_valid_next = 1'b0;
        end
        else if (emit)
        begin
            pix_next = pix_reg + 1'b1;
            case (cfg.pixel_mode)
                MODE_1BPP: sh_next = {sh_reg[6:0], 1'b0};
                MODE_2BPP: sh_next = {sh_reg[5:0], 2'b00};
                default:   sh_next = {sh_reg[3:0], 4'b0000};
            endcase
        end
    end

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        row_addr_next = row_addr_reg;
        if (emit)
        begin
            row_addr_next = base;
            if (row_end)
            begin
                col_next = '0;
                if (sprite_end)
                begin
                    row_next = '0;
                end
                else
                begin
                    row_next      = row_reg + 1'b1;
                    row_addr_next = base + DATA_W'(cfg.dest_stride);
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pix_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            row_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            pix_reg       <= pix_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            row_addr_reg  <= row_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
        if (load)
        begin
            cur_reg <= head.entry;
        end
        if (step && is_pal)
        begin
            palette_reg[cur_reg.slot[PAL_AW-1:0]] <= cur_reg.data;
        end
        if (emit)
        begin
            address_reg <= pix_addr;
            color_reg   <= pix_color;
            we_reg      <= pix_we;
            done_reg    <= sprite_end;
            last_reg    <= row_end || (pix_reg == cur_reg.npix_m1);
        end
    end

    assign out_valid    = out_valid_reg;
    assign address      = address_reg;
    assign color        = color_reg;
    assign write_enable = we_reg;
    assign sprite_done  = done_reg;
    assign last         = last_reg;

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> last_reg)
        else $error("sprite end not marked as last word");

    a_transparent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !we_reg |-> color_reg == '0)
        else $error("transparent pixel carries a color");

    a_pix_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg && !is_pal |-> pix_reg <= cur_reg.npix_m1)
        else $error("pixel index past end of source word");

    a_no_emit_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> $stable(address_reg) && $stable(color_reg))
        else $error("output register overwritten while stalled");

endmodule

### design/palette_sprite_blitter_top.sv
// An accepted source word moves through the work queue and cur_reg to the output reg.
// The output register gives one pixel per cycle while out_stall is low and work is
// queued; a 1bpp word gives 8 pixels, 2bpp 4, 4bpp 2, direct 1, fewer at a row end.
// The 4-entry work queue keeps accepting input while output stalls, until full.
// Reset (rst_n low, async) clears counters, queue pointers, valid flags and config
// registers to their defaults; palette and output data stay unknown until written.
// ----------------------------------------------------------------------------
// palette_sprite_blitter_top
// Indexed-color sprite blitter with transparency into a 32-bit framebuffer.
// ----------------------------------------------------------------------------
module palette_sprite_blitter_top #(
    parameter int MAX_DIM       = 1024,
    parameter int PALETTE_DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [psb_pkg::ADDR_W-1:0]   paddr,
    input  logic [psb_pkg::DATA_W-1:0]   pwdata,
    output logic [psb_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         op,
    input  logic [psb_pkg::SLOT_W-1:0]   palette_slot,
    input  logic [psb_pkg::DATA_W-1:0]   data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [psb_pkg::DATA_W-1:0]   address,
    output logic [psb_pkg::DATA_W-1:0]   color,
    output logic                         write_enable,
    output logic                         sprite_done,
    output logic                         last
);
    import psb_pkg::*;

    cfg_t               cfg_reg;
    logic               wr_en;
    logic [REGI_W-1:0]  reg_idx;
    logic               fifo_full, push, pop;
    entry_t             push_entry;
    fifo_head_t         head;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_mode        <= MODE_1BPP;
            cfg_reg.transparent_index <= 8'hFF;
            cfg_reg.sprite_width      <= SIZE_W'(1);
            cfg_reg.sprite_height     <= SIZE_W'(1);
            cfg_reg.dest_start        <= '0;
            cfg_reg.dest_stride       <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_PIXEL_MODE:  cfg_reg.pixel_mode        <= pwdata[MODE_W-1:0];
                REG_TRANSPARENT: cfg_reg.transparent_index <= pwdata[TIDX_W-1:0];
                REG_WIDTH:       cfg_reg.sprite_width      <= pwdata[SIZE_W-1:0];
                REG_HEIGHT:      cfg_reg.sprite_height     <= pwdata[SIZE_W-1:0];
                REG_DEST_START:  cfg_reg.dest_start        <= pwdata;
                REG_DEST_STRIDE: cfg_reg.dest_stride       <= pwdata[STRD_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PIXEL_MODE:  prdata = DATA_W'(cfg_reg.pixel_mode);
            REG_TRANSPARENT: prdata = DATA_W'(cfg_reg.transparent_index);
            REG_WIDTH:       prdata = DATA_W'(cfg_reg.sprite_width);
            REG_HEIGHT:      prdata = DATA_W'(cfg_reg.sprite_height);
            REG_DEST_START:  prdata = cfg_reg.dest_start;
            REG_DEST_STRIDE: prdata = DATA_W'(cfg_reg.dest_stride);
            default:         prdata = '0;
        endcase
    end

    psb_front #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .palette_slot (palette_slot),
        .data         (data),
        .pixel_mode   (cfg_reg.pixel_mode),
        .fifo_full    (fifo_full),
        .push         (push),
        .push_entry   (push_entry)
    );

    psb_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (fifo_full),
        .pop        (pop),
        .head       (head)
    );

    psb_back #(
        .MAX_DIM       (MAX_DIM),
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .address      (address),
        .color        (color),
        .write_enable (write_enable),
        .sprite_done  (sprite_done),
        .last         (last)
    );

endmodule
